// File: rtl/core/assert_macros.svh
// Assertion macros shared by the presence selector RTL.
// Needs nothing else; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/core/mcaps_pkg.sv
// Package of the multichannel audio presence selector: field widths, register
// indexes, default parameters and the structs passed between the modules.
// Depends on nothing.
package mcaps_pkg;

  localparam int DEF_CHANNELS    = 8;
  localparam int DEF_BUF_LEN     = 64;
  localparam int DEF_HIST_DEPTH  = 8;
  localparam int DEF_SAMPLE_BITS = 12;

  localparam int CHANNEL_W  = 3;
  localparam int SAMPLE_W   = 12;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int ZERO_W     = 13;
  localparam int MINZ_W     = 7;
  localparam int LEVEL_W    = 12;
  localparam int ITERS_W    = 4;
  localparam int INUSE_W    = 4;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ZERO_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_NOISE_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_NOISE_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_ITERATIONS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE    = 3'd5;

  typedef struct packed {
    logic [ZERO_W-1:0]  zero_level;
    logic [MINZ_W-1:0]  min_zero_count;
    logic [LEVEL_W-1:0] idle_noise_level;
    logic [LEVEL_W-1:0] active_noise_level;
    logic [ITERS_W-1:0] switch_iterations;
    logic [INUSE_W-1:0] channels_in_use;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zero_level:         13'd100,
    min_zero_count:     7'd4,
    idle_noise_level:   12'd200,
    active_noise_level: 12'd150,
    switch_iterations:  4'd3,
    channels_in_use:    4'd8
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic start;
    logic chan_init;
    logic read;
    logic judge;
    logic hist;
    logic toggle;
    logic load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic n_zero;
    logic last_k;
    logic last_ch;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [MASK_W-1:0]    open_mask;
    logic                 any_open;
    logic [CHANNEL_W-1:0] selected_channel;
    logic [MASK_W-1:0]    status_mask;
  } result_t;

endpackage

// File: rtl/core/mcaps_if.sv
// Channel interfaces of the presence selector: input items, result items and
// configuration writes. Depends on mcaps_pkg.
interface mcaps_in_if import mcaps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [CHANNEL_W-1:0] channel;
  logic [SAMPLE_W-1:0]  sample;
  modport source (output valid, action, channel, sample, input ready);
  modport sink (input valid, action, channel, sample, output ready);
endinterface

interface mcaps_out_if import mcaps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    open_mask;
  logic                 any_open;
  logic [CHANNEL_W-1:0] selected_channel;
  logic [MASK_W-1:0]    status_mask;
  modport source (output valid, open_mask, any_open, selected_channel, status_mask,
                  input ready);
  modport sink (input valid, open_mask, any_open, selected_channel, status_mask,
                output ready);
endinterface

interface mcaps_cfg_if import mcaps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/mcaps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mcaps_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/mcaps_ctrl.sv
// Sequencer of the presence selector: accepts items and steps the datapath
// through the ring walk, history update and result load. Depends on mcaps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcaps_ctrl import mcaps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  input  dp_status_t st,
  output logic       in_ready,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_JUDGE  = 4'd4;
  localparam logic [3:0] S_HIST   = 4'd5;
  localparam logic [3:0] S_TOGGLE = 4'd6;
  localparam logic [3:0] S_FINISH = 4'd7;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_EVAL) begin
            cmd.start = 1'b1;
            state_nxt = st.n_zero ? S_HIST : S_INIT;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.chan_init = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        if (st.last_k) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_nxt = st.last_ch ? S_HIST : S_INIT;
      end
      S_HIST: begin
        cmd.hist  = 1'b1;
        state_nxt = S_TOGGLE;
      end
      S_TOGGLE: begin
        cmd.toggle = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.load, !st.out_busy, "result loaded over a waiting result")
  `ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, cmd.start, state_r == S_INIT || state_r == S_HIST, "evaluation did not start")

endmodule

// File: rtl/core/mcaps_datapath.sv
// Datapath of the presence selector: sample rings, write positions, ring
// accumulators, verdict history, channel status and the result register.
// Depends on mcaps_pkg, mcaps_ram and assert_macros.svh.
`include "assert_macros.svh"

module mcaps_datapath import mcaps_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int BUF_LEN     = DEF_BUF_LEN,
  parameter int HIST_DEPTH  = DEF_HIST_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  input  logic [CHANNEL_W-1:0] in_channel,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic                 out_ready,
  output dp_status_t           st,
  output logic                 out_valid,
  output result_t              res
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NCH_W   = $clog2(CHANNELS + 1);
  localparam int POS_W   = $clog2(BUF_LEN);
  localparam int CNT_W   = $clog2(BUF_LEN + 1);
  localparam int HP_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int IT_W    = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W   = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + POS_W;
  localparam int CMPZ_W  = (SAMPLE_BITS > ZERO_W) ? SAMPLE_BITS : ZERO_W;
  localparam int CMPC_W  = (CNT_W > MINZ_W) ? CNT_W : MINZ_W;
  localparam int PAD_W   = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
  localparam int RAM_AW  = CH_W + POS_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  // Write side.
  logic [POS_W-1:0]       wp_r [CHANNELS];
  logic [CHANNELS-1:0]    wrapped_r;
  logic [CH_W-1:0]        in_ch_idx;
  logic                   in_ch_ok;
  logic [CH_W-1:0]        sel_ch;
  logic [POS_W-1:0]       sel_wp;
  logic                   sel_wrapped;
  logic                   ram_we;

  // Evaluation side.
  logic [NCH_W-1:0]       n_eff_r;
  logic [IT_W-1:0]        iters_r;
  logic [IT_W-1:0]        iters_c;
  logic [NCH_W-1:0]       n_c;
  logic [HP_W-1:0]        hpos_r;
  logic [CH_W-1:0]        ch_r;
  logic [POS_W-1:0]       k_r;
  logic [POS_W-1:0]       fill_pos_r;
  logic                   fill_full_r;
  logic                   rd_vld_r;
  logic                   rd_ok_r;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       thr_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [LEVEL_W-1:0]     level;
  logic [CHANNELS-1:0]    verdict_r;
  logic [CHANNELS-1:0]    hist_r [HIST_DEPTH];
  logic [CHANNELS-1:0]    hist_nxt [HIST_DEPTH];
  logic [CHANNELS-1:0]    status_r;
  logic [CHANNELS-1:0]    status_nxt;

  // Result.
  logic                   out_valid_r;
  result_t                res_r;
  result_t                res_c;

  assign in_ch_ok    = 32'(in_channel) < CHANNELS;
  assign in_ch_idx   = CH_W'(in_channel);
  assign sel_ch      = cmd.store ? in_ch_idx : ch_r;
  assign sel_wp      = wp_r[sel_ch];
  assign sel_wrapped = wrapped_r[sel_ch];
  assign ram_we      = cmd.store && in_ch_ok;

  mcaps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_ch_idx, sel_wp}),
    .wdata (SAMPLE_BITS'(in_sample)),
    .raddr ({ch_r, k_r}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c] <= '0;
      end
      wrapped_r <= '0;
    end else if (ram_we) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (CH_W'(c) == in_ch_idx) begin
          if (sel_wp == POS_W'(BUF_LEN - 1)) begin
            wp_r[c]      <= '0;
            wrapped_r[c] <= 1'b1;
          end else begin
            wp_r[c] <= sel_wp + POS_W'(1);
          end
        end
      end
    end
  end

  // Effective channel and iteration counts.
  always_comb begin
    if (32'(cfg.channels_in_use) > CHANNELS) begin
      n_c = NCH_W'(CHANNELS);
    end else begin
      n_c = NCH_W'(cfg.channels_in_use);
    end
    if (cfg.switch_iterations == '0) begin
      iters_c = IT_W'(1);
    end else if (32'(cfg.switch_iterations) > HIST_DEPTH) begin
      iters_c = IT_W'(HIST_DEPTH);
    end else begin
      iters_c = IT_W'(cfg.switch_iterations);
    end
  end

  assign level = status_r[ch_r] ? cfg.active_noise_level : cfg.idle_noise_level;
  // Entries a channel never wrote read as zero.
  assign smp   = rd_ok_r ? rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      hpos_r   <= '0;
      ch_r     <= '0;
      k_r      <= '0;
      n_eff_r  <= '0;
      iters_r  <= IT_W'(1);
    end else begin
      rd_vld_r <= cmd.read;
      if (cmd.start) begin
        n_eff_r <= n_c;
        iters_r <= iters_c;
        ch_r    <= '0;
        if (32'(hpos_r) >= 32'(iters_c)) begin
          hpos_r <= '0;
        end
      end
      if (cmd.chan_init) begin
        k_r <= '0;
      end
      if (cmd.read) begin
        k_r <= k_r + POS_W'(1);
      end
      if (cmd.judge) begin
        ch_r <= ch_r + CH_W'(1);
      end
      if (cmd.hist) begin
        if (32'(hpos_r) + 1 >= 32'(iters_r)) begin
          hpos_r <= '0;
        end else begin
          hpos_r <= hpos_r + HP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chan_init) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      thr_r       <= SUM_W'(level) * SUM_W'(BUF_LEN);
      fill_pos_r  <= sel_wp;
      fill_full_r <= sel_wrapped;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + SUM_W'(smp);
      if (CMPZ_W'(smp) < CMPZ_W'(cfg.zero_level)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
    if (cmd.read) begin
      rd_ok_r <= fill_full_r || (k_r < fill_pos_r);
    end
  end

  // History and status updates.
  always_comb begin
    logic all_diff;
    for (int y = 0; y < HIST_DEPTH; y++) begin
      hist_nxt[y] = hist_r[y];
      for (int i = 0; i < CHANNELS; i++) begin
        if (cmd.hist && (32'(hpos_r) == y) && (i < 32'(n_eff_r))) begin
          hist_nxt[y][i] = verdict_r[i];
        end
      end
    end
    status_nxt = status_r;
    for (int i = 0; i < CHANNELS; i++) begin
      all_diff = 1'b1;
      for (int y = 0; y < HIST_DEPTH; y++) begin
        if (y < 32'(iters_r)) begin
          all_diff = all_diff && (hist_r[y][i] != status_r[i]);
        end
      end
      if (cmd.toggle && (i < 32'(n_eff_r)) && all_diff) begin
        status_nxt[i] = ~status_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < HIST_DEPTH; y++) begin
        hist_r[y] <= '0;
      end
      status_r <= '0;
    end else begin
      for (int y = 0; y < HIST_DEPTH; y++) begin
        hist_r[y] <= hist_nxt[y];
      end
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      verdict_r[ch_r] <= (CMPC_W'(cnt_r) > CMPC_W'(cfg.min_zero_count)) && (sum_r > thr_r);
    end
  end

  // Lowest channel in use whose status is on.
  always_comb begin
    logic            found;
    logic [CH_W-1:0] sel;
    logic [PAD_W-1:0] status_pad;
    found = 1'b0;
    sel   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (status_r[i] && (i < 32'(n_eff_r))) begin
        found = 1'b1;
        sel   = CH_W'(i);
      end
    end
    status_pad = PAD_W'(status_r);
    for (int j = 0; j < MASK_W; j++) begin
      res_c.open_mask[j] = found && (32'(sel) == j);
    end
    res_c.any_open         = found;
    res_c.selected_channel = CHANNEL_W'(sel);
    res_c.status_mask      = status_pad[MASK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= res_c;
    end
  end

  assign out_valid   = out_valid_r;
  assign res         = res_r;
  assign st.n_zero   = (cfg.channels_in_use == '0);
  assign st.last_k   = (k_r == POS_W'(BUF_LEN - 1));
  assign st.last_ch  = (32'(ch_r) + 1 >= 32'(n_eff_r));
  assign st.out_busy = out_valid_r && !out_ready;

  `ASSERT_NEXT(a_hpos_in_range, clk, rst_n, cmd.hist, 32'(hpos_r) < 32'(iters_r), "history position beyond iteration count")
  `ASSERT_NEXT(a_status_only_on_toggle, clk, rst_n, !cmd.toggle, $stable(status_r), "status changed outside the toggle step")

endmodule

// File: rtl/core/multichannel_audio_presence_selector_core.sv
// Top level of the multichannel audio presence selector: configuration
// registers and the controller/datapath pair. Depends on mcaps_pkg, the
// mcaps interfaces, mcaps_ctrl and mcaps_datapath.
//
// Use: items arrive on in_if. A store item (action 0) writes its sample into
// the ring of its channel and gives no result; the next item may follow in the
// next cycle. An evaluate item (action 1) walks the ring of every channel in
// use through one RAM read port, one sample per cycle, and then puts its
// result on out_if. No item is accepted meanwhile. The result sits in an
// output register; while the receiver holds out_if.ready low, store items
// are still accepted, and a following evaluation finishes its walk and then
// waits until the register is free.
// Configuration writes on cfg_if are always accepted; write them only while
// the block is idle. Synchronous reset restores the register defaults, clears
// the write positions, history and status, and marks every ring empty; empty
// ring entries read as zero, so no clearing pass is needed.
module multichannel_audio_presence_selector_core import mcaps_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int BUF_LEN     = DEF_BUF_LEN,
  parameter int HIST_DEPTH  = DEF_HIST_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  mcaps_in_if.sink    in_if,
  mcaps_out_if.source out_if,
  mcaps_cfg_if.sink   cfg_if
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  cmd_t       cmd;
  dp_status_t st;
  result_t    res;
  logic       out_valid;

  // Configuration registers; indexes outside the list are ignored.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_ZERO_LEVEL:         cfg_nxt.zero_level         = cfg_if.data[ZERO_W-1:0];
        REG_MIN_ZERO_COUNT:     cfg_nxt.min_zero_count     = cfg_if.data[MINZ_W-1:0];
        REG_IDLE_NOISE_LEVEL:   cfg_nxt.idle_noise_level   = cfg_if.data[LEVEL_W-1:0];
        REG_ACTIVE_NOISE_LEVEL: cfg_nxt.active_noise_level = cfg_if.data[LEVEL_W-1:0];
        REG_SWITCH_ITERATIONS:  cfg_nxt.switch_iterations  = cfg_if.data[ITERS_W-1:0];
        REG_CHANNELS_IN_USE:    cfg_nxt.channels_in_use    = cfg_if.data[INUSE_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The controller decides when items are taken and steps the datapath.
  mcaps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.action),
    .st        (st),
    .in_ready  (in_if.ready),
    .cmd       (cmd)
  );

  mcaps_datapath #(
    .CHANNELS    (CHANNELS),
    .BUF_LEN     (BUF_LEN),
    .HIST_DEPTH  (HIST_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg_r),
    .in_channel (in_if.channel),
    .in_sample  (in_if.sample),
    .out_ready  (out_if.ready),
    .st         (st),
    .out_valid  (out_valid),
    .res        (res)
  );

  // Result item fields straight from the output register.
  assign out_if.valid            = out_valid;
  assign out_if.open_mask        = res.open_mask;
  assign out_if.any_open         = res.any_open;
  assign out_if.selected_channel = res.selected_channel;
  assign out_if.status_mask      = res.status_mask;

endmodule

// File: tb/multichannel_audio_presence_selector_core_tb.sv
// Self-checking testbench for the multichannel audio presence selector core.
// Uses mcaps_pkg and the mcaps interfaces. It checks every result against
// a predictor of its own, first from a directed table and then from random items.
module multichannel_audio_presence_selector_core_tb;
  import mcaps_pkg::*;

  localparam int NCH          = DEF_CHANNELS;
  localparam int RING_LEN     = DEF_BUF_LEN;
  localparam int HIST_LEN     = DEF_HIST_DEPTH;
  // Evaluation length with every channel in use; SETTLE adds a margin to it.
  localparam int EVAL_LATENCY = NCH * (RING_LEN + 3) + 3;
  localparam int SETTLE       = EVAL_LATENCY + 61;
  localparam int HOLD_CYCLES  = 3000;
  localparam int ITEMS_TARGET = 500;
  localparam int SEL_TARGET   = 60;
  localparam int LIMIT        = 800000;
  localparam int PRINT_CAP    = 100;
  localparam int PLAN_ROWS    = 35;

  // Register index that selects no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

  // One row of the directed table. For register rows, sel is the register index
  // and val the write data; for items they are the channel and the sample.
  typedef struct {
    step_kind_t      kind;
    logic            act;
    logic [2:0]      sel;
    logic [12:0]     val;
    bit              typed;
    result_t         want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  mcaps_in_if  item_bus ();
  mcaps_out_if result_bus ();
  mcaps_cfg_if reg_bus ();

  multichannel_audio_presence_selector_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (item_bus),
    .out_if (result_bus),
    .cfg_if (reg_bus)
  );

  // Predictor state.
  logic [SAMPLE_W-1:0] pcm_ring [NCH][RING_LEN];
  int                  ring_wr [NCH];
  logic [MASK_W-1:0]   verdict_log [HIST_LEN];
  int                  verdict_slot;
  logic [MASK_W-1:0]   music_on;
  cfg_t                cfg_shadow;

  result_t pending_sel [$];
  result_t oldest_sel;

  int errors;
  int items_sent;
  int selections_seen;
  int cycle_count;
  bit work_pending;
  bit gap_on;
  bit stall_on;
  bit calm;
  bit hold_req;

  plan_row_t plan [PLAN_ROWS] = '{
    // Straight after reset every ring is silent, so nothing can be open.
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b1, '0},
    // Loud bursts on the lowest and highest channel, with sample extremes.
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd7, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd7, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd7, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd7, 13'd4095, 1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd7, 13'd4095, 1'b0, '0},
    // Three agreeing verdicts switch both channels on.
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    // Out-of-range channel count and zero iterations are clamped.
    '{STEP_REG,  ACT_STORE, REG_CHANNELS_IN_USE,   13'd15, 1'b0, '0},
    '{STEP_REG,  ACT_STORE, REG_SWITCH_ITERATIONS, 13'd0,  1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_STORE, 3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    // No channel in use: nothing is opened and the status is kept.
    '{STEP_REG,  ACT_STORE, REG_CHANNELS_IN_USE,   13'd0,  1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    // One channel in use, iterations above the history depth.
    '{STEP_REG,  ACT_STORE, REG_CHANNELS_IN_USE,   13'd1,  1'b0, '0},
    '{STEP_REG,  ACT_STORE, REG_SWITCH_ITERATIONS, 13'd15, 1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    // Shrinking the iteration count leaves a stale history position behind.
    '{STEP_REG,  ACT_STORE, REG_SWITCH_ITERATIONS, 13'd2,  1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0},
    // Threshold extremes and a write to an index that holds no register.
    '{STEP_REG,  ACT_STORE, REG_ZERO_LEVEL,         13'd4096, 1'b0, '0},
    '{STEP_REG,  ACT_STORE, REG_MIN_ZERO_COUNT,     13'd64,   1'b0, '0},
    '{STEP_REG,  ACT_STORE, REG_IDLE_NOISE_LEVEL,   13'd4095, 1'b0, '0},
    '{STEP_REG,  ACT_STORE, REG_ACTIVE_NOISE_LEVEL, 13'd0,    1'b0, '0},
    '{STEP_REG,  ACT_STORE, REG_SPARE,              13'h1FFF, 1'b0, '0},
    '{STEP_ITEM, ACT_EVAL,  3'd0, 13'd0,    1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_fault(input string msg);
    if (errors < PRINT_CAP)
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // A store overwrites the oldest sample of its channel's ring.
  function automatic void store_pcm(input logic [CHANNEL_W-1:0] ch,
                                    input logic [SAMPLE_W-1:0] smp);
    pcm_ring[ch][ring_wr[ch]] = smp;
    ring_wr[ch] = (ring_wr[ch] + 1) % RING_LEN;
  endfunction

  // Judge every channel in use, update the history and status, then pick the
  // lowest channel whose status is on.
  function automatic result_t evaluate_presence();
    int      n, iters, c, k, y, quiet, differ;
    longint  total, need;
    result_t r;
    n = (cfg_shadow.channels_in_use > NCH) ? NCH : int'(cfg_shadow.channels_in_use);
    iters = (cfg_shadow.switch_iterations == 0) ? 1 : int'(cfg_shadow.switch_iterations);
    if (iters > HIST_LEN)
      iters = HIST_LEN;
    if (verdict_slot >= iters)
      verdict_slot = 0;
    for (c = 0; c < n; c++) begin
      total = 0;
      quiet = 0;
      for (k = 0; k < RING_LEN; k++) begin
        total += pcm_ring[c][k];
        if (pcm_ring[c][k] < cfg_shadow.zero_level)
          quiet++;
      end
      need = longint'(music_on[c] ? cfg_shadow.active_noise_level
                                  : cfg_shadow.idle_noise_level) * RING_LEN;
      verdict_log[verdict_slot][c] = (quiet > int'(cfg_shadow.min_zero_count)) &&
                                     (total > need);
    end
    verdict_slot = (verdict_slot + 1) % iters;
    for (c = 0; c < n; c++) begin
      differ = 0;
      for (y = 0; y < iters; y++)
        if (verdict_log[y][c] != music_on[c])
          differ++;
      if (differ == iters)
        music_on[c] = ~music_on[c];
    end
    r = '0;
    for (c = 0; c < n; c++) begin
      if (music_on[c]) begin
        r.any_open = 1'b1;
        r.selected_channel = c[CHANNEL_W-1:0];
        r.open_mask = MASK_W'(1) << c;
        break;
      end
    end
    r.status_mask = music_on;
    return r;
  endfunction

  // Offer one item, optionally after an idle burst, and predict it once taken.
  task automatic send_item(input logic act, input logic [CHANNEL_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] smp, input bit typed,
                           input result_t want);
    @(negedge clk);
    if (gap_on && !calm && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.action  <= act;
    item_bus.channel <= ch;
    item_bus.sample  <= smp;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    items_sent++;
    work_pending = 1'b1;
    if (act == ACT_STORE)
      store_pcm(ch, smp);
    else if (typed) begin
      void'(evaluate_presence());
      pending_sel.push_back(want);
    end else
      pending_sel.push_back(evaluate_presence());
  endtask

  // Stop offering, let every outstanding selection arrive, then let the block go quiet.
  task automatic settle_block();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_sel.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    work_pending = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    if (work_pending)
      settle_block();
    @(negedge clk);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= wdata;
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    case (idx)
      REG_ZERO_LEVEL:         cfg_shadow.zero_level         = wdata[ZERO_W-1:0];
      REG_MIN_ZERO_COUNT:     cfg_shadow.min_zero_count     = wdata[MINZ_W-1:0];
      REG_IDLE_NOISE_LEVEL:   cfg_shadow.idle_noise_level   = wdata[LEVEL_W-1:0];
      REG_ACTIVE_NOISE_LEVEL: cfg_shadow.active_noise_level = wdata[LEVEL_W-1:0];
      REG_SWITCH_ITERATIONS:  cfg_shadow.switch_iterations  = wdata[ITERS_W-1:0];
      REG_CHANNELS_IN_USE:    cfg_shadow.channels_in_use    = wdata[INUSE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    reg_bus.valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result_bus.ready <= 1'b1;
      end else if (stall_on && !calm && $urandom_range(0, 5) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        result_bus.ready <= 1'b1;
      end else
        result_bus.ready <= 1'b1;
    end
  end

  // Result checker: every selection is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      selections_seen++;
      if (pending_sel.size() == 0)
        log_fault($sformatf("result with nothing outstanding, status_mask %h",
                            result_bus.status_mask));
      else begin
        oldest_sel = pending_sel.pop_front();
        if (result_bus.open_mask !== oldest_sel.open_mask)
          log_fault($sformatf("open_mask %h, predicted %h",
                              result_bus.open_mask, oldest_sel.open_mask));
        if (result_bus.any_open !== oldest_sel.any_open)
          log_fault($sformatf("any_open %b, predicted %b",
                              result_bus.any_open, oldest_sel.any_open));
        if (result_bus.selected_channel !== oldest_sel.selected_channel)
          log_fault($sformatf("selected_channel %0d, predicted %0d",
                              result_bus.selected_channel, oldest_sel.selected_channel));
        if (result_bus.status_mask !== oldest_sel.status_mask)
          log_fault($sformatf("status_mask %h, predicted %h",
                              result_bus.status_mask, oldest_sel.status_mask));
      end
    end
  end

  // Watchdog.
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++)
      @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int                    row, round_no, seq, n, c, hi;
    int                    loud_pct [NCH];
    logic [CHANNEL_W-1:0]  ch;
    logic [SAMPLE_W-1:0]   smp;
    logic [CFG_DATA_W-1:0] wval;

    for (c = 0; c < NCH; c++) begin
      ring_wr[c] = 0;
      for (n = 0; n < RING_LEN; n++)
        pcm_ring[c][n] = '0;
    end
    for (c = 0; c < HIST_LEN; c++)
      verdict_log[c] = '0;
    verdict_slot     = 0;
    music_on         = '0;
    cfg_shadow       = CFG_RESET;
    errors           = 0;
    items_sent       = 0;
    selections_seen  = 0;
    work_pending     = 1'b0;
    gap_on           = 1'b0;
    stall_on         = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    rst_n            = 1'b0;
    item_bus.valid   = 1'b0;
    item_bus.action  = ACT_STORE;
    item_bus.channel = '0;
    item_bus.sample  = '0;
    reg_bus.valid    = 1'b0;
    reg_bus.index    = REG_ZERO_LEVEL;
    reg_bus.data     = '0;
    result_bus.ready = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run without idling.
    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].kind == STEP_REG)
        write_reg(plan[row].sel, plan[row].val);
      else
        send_item(plan[row].act, plan[row].sel, plan[row].val[SAMPLE_W-1:0],
                  plan[row].typed, plan[row].want);
    end

    // Random part: each round picks new settings, then plays sequences of
    // stores with a per-channel loudness profile followed by evaluations.
    for (c = 0; c < NCH; c++)
      loud_pct[c] = $urandom_range(0, 4) * 25;
    round_no = 0;
    while (items_sent < ITEMS_TARGET || selections_seen < SEL_TARGET) begin
      case ($urandom_range(0, 5))
        0:       wval = 13'd0;
        1:       wval = 13'd4096;
        2:       wval = CFG_DATA_W'($urandom_range(0, 8191));
        default: wval = CFG_DATA_W'($urandom_range(20, 600));
      endcase
      write_reg(REG_ZERO_LEVEL, wval);
      case ($urandom_range(0, 5))
        0:       wval = 13'd0;
        1:       wval = 13'd64;
        2:       wval = CFG_DATA_W'($urandom_range(0, 127));
        default: wval = CFG_DATA_W'($urandom_range(0, 24));
      endcase
      write_reg(REG_MIN_ZERO_COUNT, wval);
      case ($urandom_range(0, 5))
        0:       wval = 13'd0;
        1:       wval = 13'd4095;
        default: wval = CFG_DATA_W'($urandom_range(0, 900));
      endcase
      write_reg(REG_IDLE_NOISE_LEVEL, wval);
      case ($urandom_range(0, 5))
        0:       wval = 13'd0;
        1:       wval = 13'd4095;
        default: wval = CFG_DATA_W'($urandom_range(0, 900));
      endcase
      write_reg(REG_ACTIVE_NOISE_LEVEL, wval);
      wval = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                         : CFG_DATA_W'($urandom_range(1, 4));
      write_reg(REG_SWITCH_ITERATIONS, wval);
      wval = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                         : CFG_DATA_W'($urandom_range(1, 8));
      write_reg(REG_CHANNELS_IN_USE, wval);

      gap_on   = (round_no != 0) && ($urandom_range(0, 2) != 0);
      stall_on = (round_no != 0) && ($urandom_range(0, 2) != 0);
      // In the second round the receiver holds off long enough for the block
      // to fill its output register and stall the item channel.
      if (round_no == 1)
        hold_req = 1'b1;

      for (seq = $urandom_range(3, 6); seq > 0; seq--) begin
        calm = (items_sent >= ITEMS_TARGET - 60);
        for (c = 0; c < NCH; c++)
          if ($urandom_range(0, 2) == 0)
            loud_pct[c] = $urandom_range(0, 4) * 25;
        hi = (cfg_shadow.channels_in_use == 0) ? NCH - 1 :
             (cfg_shadow.channels_in_use > NCH) ? NCH - 1 :
             int'(cfg_shadow.channels_in_use) - 1;
        for (n = $urandom_range(4, 48); n > 0; n--) begin
          if ($urandom_range(0, 9) == 0) begin
            ch  = CHANNEL_W'($urandom);
            smp = SAMPLE_W'($urandom);
          end else begin
            ch  = ($urandom_range(0, 4) == 0) ? CHANNEL_W'($urandom_range(0, NCH - 1))
                                              : CHANNEL_W'($urandom_range(0, hi));
            smp = ($urandom_range(0, 99) < loud_pct[ch])
                  ? SAMPLE_W'($urandom_range(1500, 4095))
                  : SAMPLE_W'($urandom_range(0, 60));
          end
          send_item(ACT_STORE, ch, smp, 1'b0, '0);
        end
        for (n = $urandom_range(1, 4); n > 0; n--)
          send_item(ACT_EVAL, CHANNEL_W'($urandom), SAMPLE_W'($urandom), 1'b0, '0);
      end
      round_no++;
    end

    settle_block();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mcaps_pkg.sv
rtl/core/mcaps_if.sv
rtl/core/mcaps_ram.sv
rtl/core/mcaps_ctrl.sv
rtl/core/mcaps_datapath.sv
rtl/core/multichannel_audio_presence_selector_core.sv
tb/multichannel_audio_presence_selector_core_tb.sv
